/* hw/rtl/rtcmftf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcmftf_pkg
// Shared types and constants of the RTCM3 frame type filter.
// ----------------------------------------------------------------------------
package rtcmftf_pkg;

   localparam int unsigned HeaderLen     = 5;
   localparam int unsigned QueueDepth    = 8;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned NumAllowed    = 6;

   localparam logic [7:0]  Preamble   = 8'hD3;
   localparam logic [9:0]  MinLen     = 10'd2;
   localparam logic [9:0]  CrcBytes   = 10'd3;
   localparam logic [2:0]  HdrLastIdx = 3'(HeaderLen - 1);

   localparam logic [NumAllowed-1:0][11:0] AllowedReset = {
      12'd1230, 12'd1127, 12'd1097, 12'd1087, 12'd1077, 12'd1005
   };

   typedef enum logic [2:0] {
      CSR_FORWARD_ENABLE = 3'd0,
      CSR_TYPE_A         = 3'd1,
      CSR_TYPE_B         = 3'd2,
      CSR_TYPE_C         = 3'd3,
      CSR_TYPE_D         = 3'd4,
      CSR_TYPE_E         = 3'd5,
      CSR_TYPE_F         = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_TYPE_HI = 3'd3,
      PH_TYPE_LO = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CRC     = 3'd6
   } phase_type;

   // one queue entry: either a five byte header run or a single byte
   typedef struct packed {
      logic                          is_header;
      logic                          frame_end;
      logic [HeaderLen-1:0][7:0]     bytes;
   } entry_type;

endpackage

/* hw/rtl/rtcmftf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcmftf_front
// Configuration registers and frame parser; pushes forwarded bytes and
// header runs into the queue.
// ----------------------------------------------------------------------------
module rtcmftf_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [2:0]             csr_index,
   input  wire logic [11:0]            csr_wdata,
   input  wire logic                   byte_accept,
   input  wire logic [7:0]             rx_byte,
   output      logic                   push,
   output      rtcmftf_pkg::entry_type push_entry
);

   logic                                            enable_ff;
   logic [rtcmftf_pkg::NumAllowed-1:0][11:0]         allowed_ff;
   rtcmftf_pkg::phase_type                          phase_ff, phase_in;
   logic [9:0]                                      frame_length_ff, frame_length_in;
   logic [9:0]                                      bytes_left_ff, bytes_left_in;
   logic                                            forward_ff, forward_in;
   logic [7:0]                                      type_hi_ff, type_hi_in;
   logic [3:0][7:0]                                 hdr_ff, hdr_in;
   logic [11:0]                                     msg_type;
   logic [9:0]                                      len_full;
   logic [9:0]                                      left_dec;
   logic                                            type_match;
   logic                                            step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         allowed_ff <= rtcmftf_pkg::AllowedReset;
      end else if (csr_valid) begin
         case (csr_index)
            rtcmftf_pkg::CSR_FORWARD_ENABLE: enable_ff     <= csr_wdata[0];
            rtcmftf_pkg::CSR_TYPE_A:         allowed_ff[0] <= csr_wdata;
            rtcmftf_pkg::CSR_TYPE_B:         allowed_ff[1] <= csr_wdata;
            rtcmftf_pkg::CSR_TYPE_C:         allowed_ff[2] <= csr_wdata;
            rtcmftf_pkg::CSR_TYPE_D:         allowed_ff[3] <= csr_wdata;
            rtcmftf_pkg::CSR_TYPE_E:         allowed_ff[4] <= csr_wdata;
            rtcmftf_pkg::CSR_TYPE_F:         allowed_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign step     = byte_accept && enable_ff;
   assign msg_type = {type_hi_ff, rx_byte[7:4]};
   assign len_full = {frame_length_ff[9:8], rx_byte};
   assign left_dec = bytes_left_ff - 10'd1;

   always_comb begin
      type_match = 1'b0;
      for (int i = 0; i < rtcmftf_pkg::NumAllowed; i++) begin
         if (allowed_ff[i] == msg_type) type_match = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rtcmftf_pkg::PH_HUNT;
         frame_length_ff <= '0;
         bytes_left_ff   <= '0;
         forward_ff      <= 1'b0;
         type_hi_ff      <= '0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         forward_ff      <= forward_in;
         type_hi_ff      <= type_hi_in;
      end
   end

   // header bytes are written before they are read
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      forward_in      = forward_ff;
      type_hi_in      = type_hi_ff;
      hdr_in          = hdr_ff;
      push            = 1'b0;
      push_entry.is_header = 1'b0;
      push_entry.frame_end = 1'b0;
      push_entry.bytes     = {rx_byte, hdr_ff};
      if (step) begin
         case (phase_ff)
            rtcmftf_pkg::PH_LEN_HI: begin
               hdr_in[1]       = rx_byte;
               frame_length_in = {rx_byte[1:0], 8'd0};
               phase_in        = rtcmftf_pkg::PH_LEN_LO;
            end
            rtcmftf_pkg::PH_LEN_LO: begin
               hdr_in[2]       = rx_byte;
               frame_length_in = len_full;
               if (len_full < rtcmftf_pkg::MinLen) phase_in = rtcmftf_pkg::PH_HUNT;
               else                                phase_in = rtcmftf_pkg::PH_TYPE_HI;
            end
            rtcmftf_pkg::PH_TYPE_HI: begin
               hdr_in[3]  = rx_byte;
               type_hi_in = rx_byte;
               phase_in   = rtcmftf_pkg::PH_TYPE_LO;
            end
            rtcmftf_pkg::PH_TYPE_LO: begin
               forward_in           = type_match;
               push                 = type_match;
               push_entry.is_header = 1'b1;
               bytes_left_in        = frame_length_ff - rtcmftf_pkg::MinLen;
               if (frame_length_ff != rtcmftf_pkg::MinLen) begin
                  phase_in = rtcmftf_pkg::PH_PAYLOAD;
               end else begin
                  // no payload: straight to the crc bytes
                  bytes_left_in = rtcmftf_pkg::CrcBytes;
                  phase_in      = rtcmftf_pkg::PH_CRC;
               end
            end
            rtcmftf_pkg::PH_PAYLOAD: begin
               push             = forward_ff;
               push_entry.bytes = {32'd0, rx_byte};
               bytes_left_in    = left_dec;
               if (left_dec == 10'd0) begin
                  bytes_left_in = rtcmftf_pkg::CrcBytes;
                  phase_in      = rtcmftf_pkg::PH_CRC;
               end
            end
            rtcmftf_pkg::PH_CRC: begin
               push                 = forward_ff;
               push_entry.bytes     = {32'd0, rx_byte};
               push_entry.frame_end = (left_dec == 10'd0);
               bytes_left_in        = left_dec;
               if (left_dec == 10'd0) phase_in = rtcmftf_pkg::PH_HUNT;
            end
            default: begin
               if (rx_byte == rtcmftf_pkg::Preamble) begin
                  hdr_in[0] = rx_byte;
                  phase_in  = rtcmftf_pkg::PH_LEN_HI;
               end else begin
                  phase_in  = rtcmftf_pkg::PH_HUNT;
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/rtcmftf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcmftf_queue
// Small first-in first-out queue of parsed entries between parser and
// output sequencer.
// ----------------------------------------------------------------------------
module rtcmftf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire rtcmftf_pkg::entry_type push_entry,
   input  wire logic                   pop,
   output      rtcmftf_pkg::entry_type head,
   output      logic                   empty,
   output      logic                   full
);

   localparam int unsigned PtrW = rtcmftf_pkg::QueuePtrWidth;

   rtcmftf_pkg::entry_type mem_ff [rtcmftf_pkg::QueueDepth];
   logic [PtrW-1:0]        wr_ptr_ff;
   logic [PtrW-1:0]        rd_ptr_ff;
   logic [PtrW:0]          count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PtrW+1)'(rtcmftf_pkg::QueueDepth));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/rtcmftf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcmftf_back
// Output sequencer: expands header entries into five transfers and holds
// the result register toward the consumer.
// ----------------------------------------------------------------------------
module rtcmftf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rtcmftf_pkg::entry_type head,
   input  wire logic                   empty,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [7:0]             rsp_out_byte,
   output      logic                   rsp_run_last,
   output      logic                   rsp_frame_end
);

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic       load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (head.is_header) begin
               byte_in = head.bytes[idx_ff];
               last_in = (idx_ff == rtcmftf_pkg::HdrLastIdx);
               end_in  = 1'b0;
               if (idx_ff == rtcmftf_pkg::HdrLastIdx) begin
                  pop    = 1'b1;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end else begin
               byte_in = head.bytes[0];
               last_in = 1'b1;
               end_in  = head.frame_end;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_frame_end = end_ff;

endmodule
`default_nettype wire

/* hw/rtl/rtcm3_frame_type_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// a forwarded byte is queued when it is accepted, then registered in the output stage toward rsp
// throughput: one byte per cycle in unless the queue is full; a header run leaves as
// five transfers, absorbed by the eight-entry queue between parser and output sequencer
// reset: parser back to hunting, queue and output empty, forwarding off,
// allowed types at 1005, 1077, 1087, 1097, 1127, 1230; header store not cleared
// ----------------------------------------------------------------------------
// rtcm3_frame_type_filter_unit
// RTCM3 frame parser that forwards only frames of configured message types.
// ----------------------------------------------------------------------------
module rtcm3_frame_type_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_run_last,
   output      logic        rsp_frame_end
);

   rtcmftf_pkg::entry_type push_entry;
   rtcmftf_pkg::entry_type head;
   logic                   push;
   logic                   pop;
   logic                   empty;
   logic                   full;

   assign csr_ready = 1'b1;
   assign req_ready = !full;

   rtcmftf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .byte_accept (req_valid && req_ready),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .push_entry  (push_entry)
   );

   rtcmftf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   rtcmftf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

/* sim/rtcm3_frame_type_filter_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcm3_frame_type_filter_unit_test
// Feeds byte streams with allowed, blocked, malformed and truncated RTCM3
// frames through the filter under random stalls on both sides, predicts the
// forwarded bytes in a scoreboard and compares every output transfer.
// ----------------------------------------------------------------------------
module rtcm3_frame_type_filter_unit_test;
   import rtcmftf_pkg::*;

   localparam int unsigned CycleLimit  = 1500000;
   localparam int unsigned DrainCycles = 24;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       fend;
   } fwd_byte_type;

   class frame_filter_scoreboard;
      bit           enable;
      logic [11:0]  allowed [NumAllowed];
      phase_type    phase;
      logic [9:0]   frame_len;
      logic [11:0]  msg_type;
      logic [9:0]   remaining;
      bit           pass_frame;
      logic [7:0]   header [HeaderLen];
      fwd_byte_type expected_q [$];
      int unsigned  accepted;
      int unsigned  checked;
      int unsigned  errors;

      function new();
         enable     = 1'b0;
         phase      = PH_HUNT;
         frame_len  = '0;
         msg_type   = '0;
         remaining  = '0;
         pass_frame = 1'b0;
         accepted   = 0;
         checked    = 0;
         errors     = 0;
         for (int i = 0; i < NumAllowed; i++) allowed[i] = AllowedReset[i];
         for (int i = 0; i < HeaderLen; i++) header[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [11:0] value);
         if (idx == CSR_FORWARD_ENABLE) begin
            enable = value[0];
         end else if (idx <= CSR_TYPE_F) begin
            allowed[int'(idx) - int'(CSR_TYPE_A)] = value;
         end
      endfunction

      function void push(logic [7:0] data, logic last, logic fend);
         fwd_byte_type e;
         e.data = data;
         e.last = last;
         e.fend = fend;
         expected_q.push_back(e);
      endfunction

      function bit type_match(logic [11:0] t);
         for (int i = 0; i < NumAllowed; i++)
            if (allowed[i] == t) return 1'b1;
         return 1'b0;
      endfunction

      // advance the parser by one accepted byte and queue what it forwards
      function void note_byte(logic [7:0] b);
         if (!enable) return;
         accepted++;
         case (phase)
            PH_LEN_HI: begin
               header[1] = b;
               frame_len = {b[1:0], 8'h00};
               phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               header[2] = b;
               frame_len = frame_len | 10'(b);
               phase     = (frame_len < MinLen) ? PH_HUNT : PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
               header[3] = b;
               msg_type  = {b, 4'h0};
               phase     = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
               header[4]     = b;
               msg_type[3:0] = b[7:4];
               pass_frame    = type_match(msg_type);
               if (pass_frame)
                  for (int i = 0; i < HeaderLen; i++) push(header[i], i == HeaderLen - 1, 1'b0);
               remaining = frame_len - MinLen;
               if (remaining != 0) begin
                  phase = PH_PAYLOAD;
               end else begin
                  remaining = CrcBytes;
                  phase     = PH_CRC;
               end
            end
            PH_PAYLOAD: begin
               if (pass_frame) push(b, 1'b1, 1'b0);
               remaining = remaining - 1'b1;
               if (remaining == 0) begin
                  remaining = CrcBytes;
                  phase     = PH_CRC;
               end
            end
            PH_CRC: begin
               remaining = remaining - 1'b1;
               if (pass_frame) push(b, 1'b1, remaining == 0);
               if (remaining == 0) phase = PH_HUNT;
            end
            default: begin
               if (b == Preamble) begin
                  header[0] = b;
                  phase     = PH_LEN_HI;
               end else begin
                  phase = PH_HUNT;
               end
            end
         endcase
      endfunction

      function void check_output(logic [7:0] data, logic last, logic fend);
         fwd_byte_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected output transfer, byte %02h last %b end %b",
                     $time, data, last, fend);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (data !== e.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, e.data, data);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: run_last mismatch, expected %b, actual %b", $time, e.last, last);
            errors++;
         end
         if (fend !== e.fend) begin
            $display("%0t: frame_end mismatch, expected %b, actual %b", $time, e.fend, fend);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_frame_end;

   frame_filter_scoreboard sb;
   int unsigned cycles = 0;
   int unsigned frames_fed = 0;
   int unsigned stall_left = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;

   // allowed length-two frame, length one, length zero, noise, blocked type 4095
   logic [7:0] opening_seq [25] = '{
      8'hD3, 8'h00, 8'h02, 8'h3E, 8'hD0, 8'hAA, 8'hBB, 8'hCC,
      8'hD3, 8'hFC, 8'h01,
      8'hD3, 8'h00, 8'h00,
      8'hFF, 8'h00,
      8'hD3, 8'h00, 8'h03, 8'hFF, 8'hF0, 8'h55, 8'h00, 8'hFF, 8'hFF
   };

   rtcm3_frame_type_filter_unit uut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left = rx_quiet ? 0 : idle_len();
      end
      if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (csr_valid && csr_ready) sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_valid && req_ready) sb.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) sb.check_output(rsp_out_byte, rsp_run_last, rsp_frame_end);
         if (cycles >= CycleLimit) begin
            $display("%0t: timeout with %0d bytes still expected", $time, sb.expected_q.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic feed_byte(input logic [7:0] b);
      int unsigned gap;
      gap = tx_quiet ? 0 : idle_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every forwarded byte has been seen, plus the pipeline latency
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [11:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // keep < 0 sends the whole frame, otherwise only its first keep bytes
   task automatic send_frame(input logic [9:0] flen, input logic [11:0] mtype, input int keep);
      logic [7:0] bytes_q [$];
      bytes_q.push_back(Preamble);
      bytes_q.push_back({6'($urandom), flen[9:8]});
      bytes_q.push_back(flen[7:0]);
      if (flen >= MinLen) begin
         bytes_q.push_back(mtype[11:4]);
         bytes_q.push_back({mtype[3:0], 4'($urandom)});
         repeat (int'(flen) - int'(MinLen) + int'(CrcBytes)) bytes_q.push_back(8'($urandom));
      end
      frames_fed++;
      for (int k = 0; k < bytes_q.size() && (keep < 0 || k < keep); k++) feed_byte(bytes_q[k]);
   endtask

   function automatic logic [11:0] pick_type();
      if ($urandom_range(0, 3) != 0) return sb.allowed[$urandom_range(0, NumAllowed - 1)];
      return 12'($urandom);
   endfunction

   task automatic random_traffic(input int unsigned count);
      int unsigned goal;
      int unsigned r;
      int unsigned flen;
      goal = sb.accepted + count;
      while (sb.accepted < goal) begin
         tx_quiet = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(2, 12);
            send_frame(10'(flen), pick_type(), -1);
         end else if (r < 80) begin
            send_frame(10'($urandom_range(0, 1)), 12'h000, -1);
         end else if (r < 90) begin
            repeat ($urandom_range(1, 6))
               feed_byte(($urandom_range(0, 2) == 0) ? Preamble : 8'($urandom));
         end else begin
            flen = $urandom_range(2, 12);
            send_frame(10'(flen), pick_type(), $urandom_range(1, flen + 4));
         end
      end
   endtask

   initial begin
      logic [11:0] mid_type;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // forwarding is off after reset, so these must vanish
      for (int k = 0; k < 5; k++) feed_byte(opening_seq[k]);
      drain();
      csr_write(CSR_FORWARD_ENABLE, 12'd1);
      for (int k = 0; k < 25; k++) feed_byte(opening_seq[k]);

      drain();
      csr_write(CSR_TYPE_A, 12'd0);
      csr_write(CSR_TYPE_B, 12'd4095);
      csr_write(CSR_TYPE_C, 12'($urandom));
      csr_write(CSR_TYPE_D, 12'd1005);
      csr_write(CSR_TYPE_E, 12'd2048);
      csr_write(CSR_TYPE_F, 12'd1);
      random_traffic(35);
      tx_quiet = 1'b0;
      // length with the upper bits set
      send_frame(10'd256, 12'd4095, -1);

      // hold the parser mid-frame across a disabled stretch
      drain();
      for (int i = 0; i < NumAllowed; i++)
         csr_write(csr_index_type'(int'(CSR_TYPE_A) + i), 12'($urandom));
      mid_type = sb.allowed[2];
      send_frame(10'd6, mid_type, 4);
      drain();
      csr_write(CSR_FORWARD_ENABLE, 12'd0);
      repeat (10) feed_byte(($urandom_range(0, 1) == 0) ? Preamble : 8'($urandom));
      drain();
      csr_write(CSR_FORWARD_ENABLE, 12'd1);
      feed_byte({mid_type[3:0], 4'($urandom)});
      repeat (7) feed_byte(8'($urandom));
      random_traffic(25);

      drain();
      for (int i = 0; i < NumAllowed; i++)
         csr_write(csr_index_type'(int'(CSR_TYPE_A) + i), AllowedReset[i]);
      send_frame(10'($urandom_range(13, 30)), AllowedReset[3], -1);
      random_traffic(20);

      drain();
      if (sb.expected_q.size() != 0) begin
         $display("%0t: %0d forwarded bytes never arrived", $time, sb.expected_q.size());
         sb.errors++;
      end
      $display("fed %0d enabled bytes in %0d frames and fragments, checked %0d forwarded bytes",
               sb.accepted, frames_fed, sb.checked);
      $display("type sets: reset values, 0/4095 edges, random; forwarding paused mid-frame");
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
